// ===== sv/fw2x_pkg.sv =====
// Shared types and constants of the two-dimensional XOR Fenwick tree.
package fw2x_pkg;

  localparam int POS_W  = 7;
  localparam int WALK_W = POS_W + 1;
  localparam int DATA_W = 32;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t REG_ROWS = 1'b0;
  localparam cfg_index_t REG_COLS = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [POS_W-1:0]  row_pos;
    logic [POS_W-1:0]  col_pos;
    logic [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] prefix_xor;
  } result_t;

  typedef struct packed {
    cfg_index_t       index;
    logic [POS_W-1:0] value;
  } cfg_t;

  // Start command for the index walker.
  typedef struct packed {
    logic             start;
    logic             query;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] rows;
    logic [POS_W-1:0] cols;
  } walk_cmd_t;

  // Per-cycle status of the index walker.
  typedef struct packed {
    logic issue;
    logic last;
    logic query;
    logic busy;
  } walk_stat_t;

endpackage

// ===== sv/fw2x_chan_if.sv =====
// Valid/ready channel interface carrying one payload of a chosen type.
interface fw2x_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/fw2x_mem.sv =====
// Tree cell store: one write port, one read port with registered read data.
module fw2x_mem #(
  parameter int AW = 12
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [fw2x_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [fw2x_pkg::DATA_W-1:0] rdata
);
  import fw2x_pkg::*;

  logic [DATA_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/fw2x_walk.sv =====
// Index walker: steps the row and column chains and issues one cell read a cycle.
module fw2x_walk #(
  parameter int RAW = 6,
  parameter int CAW = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  fw2x_pkg::walk_cmd_t    cmd,
  output fw2x_pkg::walk_stat_t   stat,
  output logic [RAW+CAW-1:0]     addr
);
  import fw2x_pkg::*;

  typedef enum logic [1:0] {
    WS_IDLE = 2'b01,
    WS_RUN  = 2'b10
  } walk_state_t;

  walk_state_t       state, state_next;
  logic [WALK_W-1:0] k, k_next, l, l_next, col0;
  logic [POS_W-1:0]  h, w;
  logic              query;

  logic [WALK_W-1:0] lb_k, lb_l, k_step, l_step;
  logic              k_end, l_end, last;

  always_comb begin
    lb_k   = k & (~k + WALK_W'(1));
    lb_l   = l & (~l + WALK_W'(1));
    k_step = query ? (k - lb_k) : (k + lb_k);
    l_step = query ? (l - lb_l) : (l + lb_l);
    k_end  = query ? (k_step == '0) : (k_step > {1'b0, h});
    l_end  = query ? (l_step == '0) : (l_step > {1'b0, w});
    last   = k_end && l_end;

    state_next = state;
    k_next     = k;
    l_next     = l;
    case (state)
      WS_IDLE: begin
        if (cmd.start) begin
          state_next = WS_RUN;
          k_next     = {1'b0, cmd.row};
          l_next     = {1'b0, cmd.col};
        end
      end
      WS_RUN: begin
        if (l_end) begin
          k_next = k_step;
          l_next = col0;
        end else begin
          l_next = l_step;
        end
        if (last) begin
          state_next = WS_IDLE;
        end
      end
      default: state_next = WS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= WS_IDLE;
    end else begin
      state <= state_next;
    end
    k <= k_next;
    l <= l_next;
    if (state == WS_IDLE && cmd.start) begin
      col0  <= {1'b0, cmd.col};
      h     <= cmd.rows;
      w     <= cmd.cols;
      query <= cmd.query;
    end
  end

  assign stat.issue = (state == WS_RUN);
  assign stat.last  = last;
  assign stat.query = query;
  assign stat.busy  = (state == WS_RUN);
  assign addr       = {RAW'(k - WALK_W'(1)), CAW'(l - WALK_W'(1))};

endmodule

// ===== sv/fenwick_tree_2d_xor.sv =====
// Top level of the two-dimensional Fenwick tree with XOR as its combining operation.
//
// Channels: "item" takes one transaction per update or query (kind, row_pos,
// col_pos, value); "result" gives one prefix_xor transaction per query and none
// per update; "cfg" writes rows_in_use (index 0) or cols_in_use (index 1) and
// is always ready. All channels complete a transaction when valid and ready
// are both high at a rising edge of clk.
// Timing: an item touches N tree cells, one read a cycle from the single
// read port of the cell memory, with the write-back in the cycle after each read.
// N is at most (log2 rows + 1) * (log2 cols + 1), 49 at 64 by 64. The next
// item is taken once the walk has drained, and after a query once its sum
// has moved into the output register. An item that touches no cell starts no
// walk; a query of that kind yields a zero result.
// Reset: rst (synchronous) restores both sizes to 64 and starts a clearing
// pass that writes zero to every cell, 2**(RAW+CAW) cells (4096 at defaults).
// "item" is not ready during the pass; configuration writes still go through.
// Stalls: the result waits in an output register; the next item is accepted
// meanwhile, and a later query waits for the register to empty.
module fenwick_tree_2d_xor #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk,
  input  logic        rst,
  fw2x_chan_if.sink   item,
  fw2x_chan_if.source result,
  fw2x_chan_if.sink   cfg
);
  import fw2x_pkg::*;

  // Address bits of a row and of a column within the cell memory.
  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW  = RAW + CAW;
  // The largest size a 7-bit register can name, bounded by the tree's extent.
  localparam int ROW_CAP = (MAX_ROWS < 127) ? MAX_ROWS : 127;
  localparam int COL_CAP = (MAX_COLS < 127) ? MAX_COLS : 127;

  // Configuration registers.
  logic [POS_W-1:0] rows_reg, cols_reg;
  logic [POS_W-1:0] h, w;

  // Clearing pass after reset.
  logic          clr_active;
  logic [AW-1:0] clr_addr;

  // Item control.
  logic              busy;
  logic              q_done;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] upd_val;
  logic              accept;
  logic [POS_W-1:0]  row_c, col_c;
  logic              need_walk;

  // Stage that receives read data in the cycle after the walker issues a read.
  logic          d_valid, d_last, d_query;
  logic [AW-1:0] d_addr;

  // Output register.
  logic              res_valid;
  logic [DATA_W-1:0] res_data;
  logic              res_load;

  walk_cmd_t         wcmd;
  walk_stat_t        wstat;
  logic [AW-1:0]     raddr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  assign h = (rows_reg > POS_W'(ROW_CAP)) ? POS_W'(ROW_CAP) : rows_reg;
  assign w = (cols_reg > POS_W'(COL_CAP)) ? POS_W'(COL_CAP) : cols_reg;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_reg <= POS_W'(64);
      cols_reg <= POS_W'(64);
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_ROWS: rows_reg <= cfg.data.value;
        REG_COLS: cols_reg <= cfg.data.value;
        default:  ;
      endcase
    end
  end

  // A new item waits for the previous walk to drain and for any finished
  // query sum to move into the output register.
  assign item.ready = !clr_active && !busy && !q_done;
  assign accept     = item.valid && item.ready;

  // Queries clamp to the size in use. An update that is valid at all lies
  // inside the size, so the clamp leaves it unchanged.
  assign row_c = (item.data.row_pos > h) ? h : item.data.row_pos;
  assign col_c = (item.data.col_pos > w) ? w : item.data.col_pos;

  always_comb begin
    if (item.data.kind == KIND_QUERY) begin
      need_walk = (row_c != '0) && (col_c != '0);
    end else begin
      need_walk = (item.data.row_pos != '0) && (item.data.col_pos != '0) &&
                  (item.data.row_pos <= h) && (item.data.col_pos <= w);
    end
  end

  assign wcmd.start = accept && need_walk;
  assign wcmd.query = (item.data.kind == KIND_QUERY);
  assign wcmd.row   = row_c;
  assign wcmd.col   = col_c;
  assign wcmd.rows  = h;
  assign wcmd.cols  = w;

  fw2x_walk #(
    .RAW (RAW),
    .CAW (CAW)
  ) u_walk (
    .clk  (clk),
    .rst  (rst),
    .cmd  (wcmd),
    .stat (wstat),
    .addr (raddr)
  );

  // Clearing pass: one cell a cycle from address zero up.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == '1) begin
        clr_active <= 1'b0;
      end
    end
  end

  // The cells of one walk are all distinct, so the write-back of one cell
  // never meets the read of the next at the same address.
  assign mem_we    = clr_active || (d_valid && !d_query);
  assign mem_waddr = clr_active ? clr_addr : d_addr;
  assign mem_wdata = clr_active ? '0 : (mem_rdata ^ upd_val);

  fw2x_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= wstat.issue;
    end
    d_last  <= wstat.last;
    d_query <= wstat.query;
    d_addr  <= raddr;
  end

  assign res_load = q_done && (!res_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      q_done <= 1'b0;
    end else begin
      if (wcmd.start) begin
        busy <= 1'b1;
      end else if (d_valid && d_last) begin
        busy <= 1'b0;
      end
      if (accept && wcmd.query && !need_walk) begin
        q_done <= 1'b1;
      end else if (d_valid && d_last && d_query) begin
        q_done <= 1'b1;
      end else if (res_load) begin
        q_done <= 1'b0;
      end
    end
    if (accept) begin
      upd_val <= item.data.value;
      acc     <= '0;
    end else if (d_valid && d_query) begin
      acc <= acc ^ mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (res_load) begin
      res_data <= acc;
    end
  end

  assign result.valid           = res_valid;
  assign result.data.prefix_xor = res_data;

  // The update write-back must never collide with the clearing pass.
  a_no_walk_in_clear: assert property (@(posedge clk) disable iff (rst)
    !(clr_active && (d_valid || wstat.issue)))
    else $error("cell access during clearing pass");

  // The walker only runs while an item is held busy.
  a_walk_under_busy: assert property (@(posedge clk) disable iff (rst)
    wstat.issue |-> busy)
    else $error("walker issues a read outside a busy item");

  // The last cell of a query walk hands its sum over to the output path.
  a_query_done: assert property (@(posedge clk) disable iff (rst)
    (d_valid && d_last && d_query) |=> q_done)
    else $error("finished query sum not marked done");

  // A loaded result shows up on the output channel.
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (result.valid && result.data.prefix_xor == $past(acc)))
    else $error("result register lost a query sum");

endmodule
